// File: rtl/core/tosh_pkg.sv
// Package for the timestamped sample history: sizes, item kinds, payload widths.
// No dependencies.
`timescale 1ns / 1ps
package tosh_pkg;
  localparam int MAX_SAMPLES = 1024;
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_BETWEEN = 2'd1,
    KIND_TRIM = 2'd2,
    KIND_LAST_PAIR = 2'd3
  } kind_t;

  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] dropped;
    logic [CNT_W-1:0] entries;
    logic [47:0] lock_delta;
    logic [47:0] op_delta;
    logic found;
  } result_t;
endpackage

// File: rtl/core/timestamped_op_sample_history_top.sv
// Top level of the timestamped sample history: ring store and item sequencer.
// Depends on tosh_pkg.
`timescale 1ns / 1ps
// Keeps up to 1024 samples (stamp, cumulative ops, lock count) in one
// synchronous RAM with a registered read port. One item at a time. A record
// goes straight to the output state when nothing has to be read (sampling off,
// period not reached, or empty store) and otherwise reads the newest stamp
// first (S_RD, S_CHK); a last-pair query reads the newest and then the
// next-newest entry (S_RD, S_CHK, S_RD2, S_CHK2), or goes straight to output
// with fewer than two samples. An ops-between query (non-empty store) or a trim
// (more than two entries) walks the ring from the oldest entry through S_RD and
// S_CHK for each entry visited. The result sits in an output register; the next
// item is taken once the previous result has left, so out_tready low holds it off.
module timestamped_op_sample_history_top
  import tosh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_tvalid,
  output logic in_tready,
  // tdata: stamp[63:0], start_stamp[127:64], ops_added[159:128], lock_total[207:160]
  input  logic [207:0] in_tdata,
  // tuser: kind[1:0]
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: found[0], op_delta[48:1], lock_delta[96:49], entries[107:97],
  //        dropped[118:108], zero fill to 120
  output logic [119:0] out_tdata
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,   // read issued, wait
    S_CHK  = 6'b000100,   // data valid
    S_RD2  = 6'b001000,
    S_CHK2 = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r;
  logic [31:0] period_r;
  logic enable_r;
  logic [IDX_W-1:0] oldest_r;
  logic [CNT_W-1:0] held_r;
  logic [47:0] total_r, last_store_r;
  logic [1:0] kind_r;
  logic [63:0] stamp_r, start_r;
  logic [47:0] lock_in_r;
  logic [CNT_W-1:0] pos_r, dropped_r;
  logic have_prev_r;
  logic [47:0] prev_r, ops_a_r, lock_a_r;
  result_t res_r;
  logic out_valid_r;

  // RAM: stamp, ops, lock per entry
  logic [159:0] mem [MAX_SAMPLES];
  logic [159:0] rd_q;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic we;
  logic [159:0] wd;
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wd;
    rd_q <= mem[rd_addr];
  end
  wire [63:0] q_stamp = rd_q[63:0];
  wire [47:0] q_ops = rd_q[111:64];
  wire [47:0] q_lock = rd_q[159:112];

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] o,
                                            input logic [CNT_W-1:0] p);
    logic [CNT_W:0] s;
    s = {{(CNT_W+1-IDX_W){1'b0}}, o} + {1'b0, p};
    if (s >= (CNT_W+1)'(MAX_SAMPLES)) s = s - (CNT_W+1)'(MAX_SAMPLES);
    return s[IDX_W-1:0];
  endfunction

  logic [47:0] new_total;
  assign new_total = total_r + {16'd0, in_tdata[159:128]};
  wire pass_period = ((new_total - last_store_r) >= {16'd0, period_r});
  wire [CNT_W-1:0] held_m1 = held_r - CNT_W'(1);

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  wire in_acc = in_tvalid && in_tready;
  wire [IDX_W-1:0] wr_slot = (held_r < CNT_W'(MAX_SAMPLES)) ? slot(oldest_r, held_r)
                                                           : slot(oldest_r, held_m1);

  always_comb begin
    rd_addr = slot(oldest_r, pos_r);
    if (state_r == S_IDLE) rd_addr = slot(oldest_r, held_m1);
    we = 1'b0;
    wr_addr = wr_slot;
    wd = {lock_in_r, total_r, stamp_r};
    if (state_r == S_CHK && kind_r == KIND_RECORD &&
        (held_r == '0 || stamp_r > q_stamp)) we = 1'b1;
    if (state_r == S_IDLE && in_acc && in_tuser == KIND_RECORD && enable_r &&
        pass_period && held_r == '0) begin
      we = 1'b1;
      wd = {in_tdata[207:160], new_total, in_tdata[63:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      period_r <= 32'd1000;
      enable_r <= 1'b1;
      oldest_r <= '0;
      held_r <= '0;
      total_r <= '0;
      last_store_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PERIOD) period_r <= cfg_data;
        else enable_r <= cfg_data[0];
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          kind_r <= in_tuser;
          stamp_r <= in_tdata[63:0];
          start_r <= in_tdata[127:64];
          lock_in_r <= in_tdata[207:160];
          res_r <= '0;
          dropped_r <= '0;
          have_prev_r <= 1'b0;
          // record and last-pair read the newest entry first, walks start at the oldest
          pos_r <= (in_tuser == KIND_RECORD || in_tuser == KIND_LAST_PAIR) ? held_m1 : '0;
          unique case (kind_t'(in_tuser))
            KIND_RECORD: begin
              if (!enable_r || !pass_period) begin
                if (enable_r) total_r <= new_total;
                state_r <= S_OUT;
              end else if (held_r == '0) begin
                total_r <= new_total;
                last_store_r <= new_total;
                held_r <= CNT_W'(1);
                state_r <= S_OUT;
              end else begin
                total_r <= new_total;
                state_r <= S_RD;
              end
            end
            KIND_BETWEEN: state_r <= (held_r == '0) ? S_OUT : S_RD;
            KIND_TRIM: state_r <= (held_r > CNT_W'(2)) ? S_RD : S_OUT;
            default: state_r <= (held_r >= CNT_W'(2)) ? S_RD : S_OUT;
          endcase
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          unique case (kind_t'(kind_r))
            KIND_RECORD: begin
              if (stamp_r > q_stamp) begin
                last_store_r <= total_r;
                if (held_r < CNT_W'(MAX_SAMPLES)) held_r <= held_r + CNT_W'(1);
              end
              state_r <= S_OUT;
            end
            KIND_BETWEEN: begin
              // walk from oldest; pos_r is the entry just read
              if (!have_prev_r && start_r <= q_stamp) begin
                have_prev_r <= 1'b1;
                prev_r <= q_ops;
              end
              if (stamp_r <= q_stamp || pos_r == held_m1) begin
                if (have_prev_r || start_r <= q_stamp) begin
                  res_r.found <= 1'b1;
                  res_r.op_delta <= q_ops - (have_prev_r ? prev_r : q_ops);
                end
                state_r <= S_OUT;
              end else begin
                pos_r <= pos_r + CNT_W'(1);
                state_r <= S_RD;
              end
            end
            KIND_TRIM: begin
              if (q_stamp < stamp_r) begin
                oldest_r <= slot(oldest_r, CNT_W'(1));
                held_r <= held_m1;
                dropped_r <= dropped_r + CNT_W'(1);
                state_r <= (held_r > CNT_W'(3)) ? S_RD : S_OUT;
              end else state_r <= S_OUT;
            end
            default: begin
              ops_a_r <= q_ops;
              lock_a_r <= q_lock;
              pos_r <= held_r - CNT_W'(2);
              state_r <= S_RD2;
            end
          endcase
        end
        S_RD2: state_r <= S_CHK2;
        S_CHK2: begin
          res_r.found <= 1'b1;
          res_r.op_delta <= ops_a_r - q_ops;
          res_r.lock_delta <= lock_a_r - q_lock;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          res_r.entries <= held_r;
          res_r.dropped <= dropped_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, res_r};

  // Walk position never passes the held count.
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && kind_r == KIND_BETWEEN) |-> pos_r < held_r)
    else $error("walk past held entries");
  // Held count never exceeds the store depth.
  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(MAX_SAMPLES)) else $error("held count overflow");
  // Trim never leaves fewer than two entries once it drops one.
  a_trim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.dropped != '0) |-> res_r.entries >= CNT_W'(2))
    else $error("trim kept fewer than two");
  // No item taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accepted while result pending");
endmodule
